### rtl/msp_pkg.sv
package msp_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_GT     = 8'h3E;

    localparam logic [7:0] CMD_BASE = 8'd99;
    localparam logic [7:0] CMD_TOP  = 8'd130;

    localparam logic [31:0] MASK_RESET = 32'hFFFF_FFFF;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DOLLAR = 3'd1;
    localparam logic [2:0] PH_M      = 3'd2;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_FAIL  = 2'd2,
        KIND_HDR   = 2'd3
    } kind_t;

    typedef struct packed {
        logic       take_size;
        logic       take_cmd;
        logic       fill_byte;
        logic       discard_step;
        logic       emit_hdr;
        logic [2:0] hdr_phase;
        logic       emit_fail;
        logic       emit_empty;
        logic       replay_start;
        logic       replay_fetch;
        logic       replay_emit;
    } cmd_t;

    typedef struct packed {
        logic is_dollar;
        logic is_m;
        logic is_gt;
        logic oversize;
        logic interesting;
        logic size_zero;
        logic fill_done;
        logic discard_done;
        logic xor_match;
        logic replay_last;
        logic out_free;
    } status_t;

endpackage

### rtl/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/msp_ctrl.sv
module msp_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  msp_pkg::status_t st,
    output msp_pkg::cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DOLLAR  = 10'b00_0000_0010,
        S_M       = 10'b00_0000_0100,
        S_SIZE    = 10'b00_0000_1000,
        S_CMD     = 10'b00_0001_0000,
        S_FILL    = 10'b00_0010_0000,
        S_CSUM    = 10'b00_0100_0000,
        S_DISCARD = 10'b00_1000_0000,
        S_RD      = 10'b01_0000_0000,
        S_WR      = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   replaying;
    logic   accept;

    assign replaying = (state_reg == S_RD) || (state_reg == S_WR);
    assign in_stall  = replaying || !st.out_free;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (st.is_dollar)
                    begin
                        state_next = S_DOLLAR;
                    end
                    else
                    begin
                        cmd.emit_hdr  = 1'b1;
                        cmd.hdr_phase = msp_pkg::PH_IDLE;
                    end
                end
            end
            S_DOLLAR:
            begin
                if (accept)
                begin
                    if (st.is_m)
                    begin
                        state_next = S_M;
                    end
                    else
                    begin
                        cmd.emit_hdr  = 1'b1;
                        cmd.hdr_phase = msp_pkg::PH_DOLLAR;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_M:
            begin
                if (accept)
                begin
                    if (st.is_gt)
                    begin
                        state_next = S_SIZE;
                    end
                    else
                    begin
                        cmd.emit_hdr  = 1'b1;
                        cmd.hdr_phase = msp_pkg::PH_M;
                        state_next    = S_IDLE;
                    end
                end
            end
            S_SIZE:
            begin
                if (accept)
                begin
                    if (st.oversize)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.take_size = 1'b1;
                        state_next    = S_CMD;
                    end
                end
            end
            S_CMD:
            begin
                if (accept)
                begin
                    cmd.take_cmd = 1'b1;
                    priority if (!st.interesting)
                    begin
                        state_next = S_DISCARD;
                    end
                    else if (st.size_zero)
                    begin
                        state_next = S_CSUM;
                    end
                    else
                    begin
                        state_next = S_FILL;
                    end
                end
            end
            S_FILL:
            begin
                if (accept)
                begin
                    cmd.fill_byte = 1'b1;
                    if (st.fill_done)
                    begin
                        state_next = S_CSUM;
                    end
                end
            end
            S_CSUM:
            begin
                if (accept)
                begin
                    state_next = S_IDLE;
                    priority if (!st.xor_match)
                    begin
                        cmd.emit_fail = 1'b1;
                    end
                    else if (st.size_zero)
                    begin
                        cmd.emit_empty = 1'b1;
                    end
                    else
                    begin
                        cmd.replay_start = 1'b1;
                        state_next       = S_RD;
                    end
                end
            end
            S_DISCARD:
            begin
                if (accept)
                begin
                    if (st.discard_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.discard_step = 1'b1;
                    end
                end
            end
            S_RD:
            begin
                cmd.replay_fetch = 1'b1;
                state_next       = S_WR;
            end
            S_WR:
            begin
                if (st.out_free)
                begin
                    cmd.replay_emit = 1'b1;
                    state_next      = st.replay_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/msp_dp.sv
module msp_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_data,
    input  msp_pkg::cmd_t    cmd,
    output msp_pkg::status_t st,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       command_id,
    output logic [6:0]       frame_size,
    output logic [7:0]       data_byte,
    output logic [5:0]       byte_index,
    output logic [2:0]       parser_phase,
    output logic             last
);

    localparam int AW = msp_pkg::ADDR_W;

    logic [31:0]   mask_reg;
    logic [6:0]    size_reg;
    logic [7:0]    command_reg;
    logic [6:0]    byte_count_reg;
    logic [7:0]    xor_reg;
    logic [AW-1:0] ridx_reg;

    logic          out_valid_reg;
    logic [1:0]    kind_reg;
    logic [7:0]    command_id_reg;
    logic [6:0]    frame_size_reg;
    logic [7:0]    data_byte_reg;
    logic [5:0]    byte_index_reg;
    logic [2:0]    parser_phase_reg;
    logic          last_reg;

    logic [7:0]    rd_data;
    logic [4:0]    mask_bit;
    logic          in_range;
    logic [6:0]    count_inc;
    logic          load;

    msp_ram #(
        .WIDTH (8),
        .DEPTH (msp_pkg::MAX_LEN)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.fill_byte),
        .wr_addr (byte_count_reg[AW-1:0]),
        .wr_data (in_byte),
        .rd_en   (cmd.replay_fetch),
        .rd_addr (ridx_reg),
        .rd_data (rd_data)
    );

    assign mask_bit  = 5'(in_byte - msp_pkg::CMD_BASE);
    assign in_range  = (in_byte >= msp_pkg::CMD_BASE) && (in_byte <= msp_pkg::CMD_TOP);
    assign count_inc = byte_count_reg + 7'd1;

    assign st.out_free     = !out_valid_reg || !out_stall;
    assign st.is_dollar    = (in_byte == msp_pkg::CH_DOLLAR);
    assign st.is_m         = (in_byte == msp_pkg::CH_M);
    assign st.is_gt        = (in_byte == msp_pkg::CH_GT);
    assign st.oversize     = (in_byte > 8'(msp_pkg::MAX_LEN));
    assign st.interesting  = !in_range || mask_reg[mask_bit];
    assign st.size_zero    = (size_reg == 7'd0);
    assign st.fill_done    = (count_inc >= size_reg);
    assign st.discard_done = (byte_count_reg >= size_reg);
    assign st.xor_match    = (xor_reg == in_byte);
    assign st.replay_last  = (7'(ridx_reg) + 7'd1 == size_reg);

    assign load = cmd.emit_hdr || cmd.emit_fail || cmd.emit_empty || cmd.replay_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg       <= msp_pkg::MASK_RESET;
            size_reg       <= '0;
            command_reg    <= '0;
            byte_count_reg <= '0;
            xor_reg        <= '0;
            ridx_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_data;
            end
            if (cmd.take_size)
            begin
                size_reg <= in_byte[6:0];
                xor_reg  <= in_byte;
            end
            if (cmd.take_cmd)
            begin
                command_reg    <= in_byte;
                byte_count_reg <= '0;
                xor_reg        <= xor_reg ^ in_byte;
            end
            if (cmd.fill_byte)
            begin
                byte_count_reg <= count_inc;
                xor_reg        <= xor_reg ^ in_byte;
            end
            if (cmd.discard_step)
            begin
                byte_count_reg <= count_inc;
            end
            if (cmd.replay_start)
            begin
                ridx_reg <= '0;
            end
            else if (cmd.replay_emit)
            begin
                ridx_reg <= ridx_reg + AW'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            priority if (cmd.emit_hdr)
            begin
                kind_reg         <= msp_pkg::KIND_HDR;
                command_id_reg   <= '0;
                frame_size_reg   <= '0;
                data_byte_reg    <= in_byte;
                byte_index_reg   <= '0;
                parser_phase_reg <= cmd.hdr_phase;
                last_reg         <= 1'b1;
            end
            else if (cmd.emit_fail)
            begin
                kind_reg         <= msp_pkg::KIND_FAIL;
                command_id_reg   <= command_reg;
                frame_size_reg   <= size_reg;
                data_byte_reg    <= in_byte;
                byte_index_reg   <= '0;
                parser_phase_reg <= msp_pkg::PH_IDLE;
                last_reg         <= 1'b1;
            end
            else if (cmd.emit_empty)
            begin
                kind_reg         <= msp_pkg::KIND_EMPTY;
                command_id_reg   <= command_reg;
                frame_size_reg   <= size_reg;
                data_byte_reg    <= '0;
                byte_index_reg   <= '0;
                parser_phase_reg <= msp_pkg::PH_IDLE;
                last_reg         <= 1'b1;
            end
            else
            begin
                kind_reg         <= msp_pkg::KIND_DATA;
                command_id_reg   <= command_reg;
                frame_size_reg   <= size_reg;
                data_byte_reg    <= rd_data;
                byte_index_reg   <= 6'(ridx_reg);
                parser_phase_reg <= msp_pkg::PH_IDLE;
                last_reg         <= st.replay_last;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign command_id   = command_id_reg;
    assign frame_size   = frame_size_reg;
    assign data_byte    = data_byte_reg;
    assign byte_index   = byte_index_reg;
    assign parser_phase = parser_phase_reg;
    assign last         = last_reg;

endmodule

### rtl/msp_frame_parser.sv
// A header error, checksum failure or empty frame request appears in the cycle
// after the byte that causes it. A good payload frame replays from the payload RAM
// after its checksum byte: each request is read, then loaded once the output is free.
// Throughput: one byte per cycle while parsing and output is free; input stalls in replay.
// Reset: rst_n asynchronous, active low; parser idle, interest mask all ones.
module msp_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  command_id,
    output logic [6:0]  frame_size,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_index,
    output logic [2:0]  parser_phase,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    msp_pkg::cmd_t    cmd;
    msp_pkg::status_t st;

    assign cfg_ready = 1'b1;

    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    msp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_byte      (in_byte),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .command_id   (command_id),
        .frame_size   (frame_size),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .parser_phase (parser_phase),
        .last         (last)
    );

endmodule

### rtl/msp_checker.sv
module msp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  command_id,
    input logic [6:0]  frame_size,
    input logic [7:0]  data_byte,
    input logic [5:0]  byte_index,
    input logic [2:0]  parser_phase,
    input logic        last
);

    // a byte is never taken while a request is held back
    a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !(out_valid && out_stall))
        else $error("byte accepted while output blocked");

    a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == msp_pkg::KIND_HDR) |->
            (last && command_id == 8'd0 && frame_size == 7'd0 && byte_index == 6'd0))
        else $error("header error request malformed");

    a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == msp_pkg::KIND_DATA) |->
            (frame_size != 7'd0 && {1'b0, byte_index} < frame_size && parser_phase == 3'd0))
        else $error("payload request index out of frame");

    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == msp_pkg::KIND_FAIL || kind == msp_pkg::KIND_EMPTY)) |->
            (last && parser_phase == 3'd0))
        else $error("single request not marked last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(data_byte) && $stable(kind)))
        else $error("stalled request changed");

endmodule

bind msp_frame_parser msp_checker u_msp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .command_id   (command_id),
    .frame_size   (frame_size),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .parser_phase (parser_phase),
    .last         (last)
);
